@@ sv/psu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter unit.
package psu_pkg;

    localparam int DATA_W              = 8;
    localparam int BPP_W               = 3;
    localparam int ROWB_W              = 13;
    localparam int CFG_DATA_W          = 13;
    localparam int FILT_W              = 3;
    localparam int MAX_ROW_BYTES_DEF   = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd4;
    localparam logic [ROWB_W-1:0] ROWB_RESET = 13'd4096;

    typedef enum logic [FILT_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef enum logic [0:0] {
        CFG_BPP       = 1'b0,
        CFG_ROW_BYTES = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [DATA_W-1:0]    wdata;
    } t_mem_ctl;

endpackage

@@ sv/psu_line_mem.sv @@
// Prior-row line store: one write port, one registered read port.
module psu_line_mem #(
    parameter int DEPTH = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  psu_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]             i_waddr,
    input  logic [AW-1:0]             i_raddr,
    output logic [psu_pkg::DATA_W-1:0] o_rdata
);
    import psu_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_ctl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/png_scanline_unfilter_unit.sv @@
// Top level of the PNG scanline unfilter unit.
//
// Input stream (s_axis): one inflated byte per request in tdata, tuser set on
// the first byte of a new image. The first byte of every row is its filter
// type and yields no output; each of the next row_bytes bytes yields one
// reconstructed byte on m_axis (tdata), with tlast on the last byte of the row
// and tuser set for every byte of a row whose filter type was above 4.
// Configuration: write i_cfg_data to register i_cfg_idx (0 bytes per pixel,
// 1 row bytes) while i_cfg_we is high; write only while the block is idle.
// Throughput: one byte per clock while m_axis is not stalled. A data byte
// accepted on s_axis reaches m_axis through two register stages (line store
// read plus working stage, then output register).
// The previous row lives in a single-port-read line store read at accept, ahead
// of the reconstruction stage; consecutive bytes touch different entries.
// Reset: the block waits for a filter byte of a first row, bytes per pixel is
// 4 and row bytes 4096; the line store is not cleared.
// Stall: when m_axis_tready is low the output register and the working stage
// hold, and s_axis_tready drops once both are full.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [psu_pkg::DATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tuser,   // [0] image_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [psu_pkg::DATA_W-1:0]    m_axis_tdata,   // [7:0] pixel_byte
    output logic                          m_axis_tlast,   // row_end
    output logic                          m_axis_tuser,   // [0] bad_filter
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psu_pkg::*;

    localparam int AW   = $clog2(MAX_ROW_BYTES);
    localparam int LW   = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW   = (LW > ROWB_W) ? LW : ROWB_W;
    localparam int PIW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW   = 4;

    function automatic logic [DATA_W-1:0] paeth(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        logic signed [9:0] pa_s;
        logic signed [9:0] pb_s;
        logic signed [9:0] pc_s;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        pa_s = $signed({2'b00, b}) - $signed({2'b00, c});
        pb_s = $signed({2'b00, a}) - $signed({2'b00, c});
        pc_s = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa   = pa_s[9] ? 10'(-pa_s) : 10'(pa_s);
        pb   = pb_s[9] ? 10'(-pb_s) : 10'(pb_s);
        pc   = pc_s[9] ? 10'(-pc_s) : 10'(pc_s);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    // configuration
    logic [BPP_W-1:0]  r_bpp;
    logic [ROWB_W-1:0] r_row_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_RESET;
            r_row_bytes <= ROWB_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[ROWB_W-1:0];
                default: ;
            endcase
        end
    end

    logic [BW-1:0]  bpp_eff;
    logic [PIW-1:0] win_idx;
    logic [CW-1:0]  len_eff;

    always_comb begin
        bpp_eff = {1'b0, r_bpp};
        if (bpp_eff == '0) begin
            bpp_eff = BW'(1);
        end else if (bpp_eff > BW'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BW'(MAX_PIXEL_BYTES);
        end
        win_idx = PIW'(bpp_eff - BW'(1));
        len_eff = CW'(r_row_bytes);
        if (len_eff == '0) begin
            len_eff = CW'(1);
        end else if (len_eff > CW'(MAX_ROW_BYTES)) begin
            len_eff = CW'(MAX_ROW_BYTES);
        end
    end

    // front-end row state
    logic          r_await;
    logic          r_first;
    logic [AW-1:0] r_col;
    t_filter       r_filter;
    logic          r_bad;

    // working stage
    logic                r_s1_valid;
    logic                r_s1_hdr;
    logic [DATA_W-1:0]   r_s1_x;
    logic                r_s1_first;
    logic                r_s1_last;
    logic                r_s1_bad;
    t_filter             r_s1_filter;
    logic [AW-1:0]       r_s1_col;

    // windows and output register
    logic [DATA_W-1:0] r_left   [MAX_PIXEL_BYTES];
    logic [DATA_W-1:0] r_upleft [MAX_PIXEL_BYTES];
    logic              r_m_valid;
    logic [DATA_W-1:0] r_m_data;
    logic              r_m_last;
    logic              r_m_bad;

    logic              in_acc;
    logic              s1_adv;
    logic              eff_await;
    logic              eff_first;
    logic              in_last;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] pred;
    logic [DATA_W-1:0] recon;
    logic [DATA_W:0]   ab_sum;
    t_mem_ctl          mem_ctl;

    assign s1_adv        = r_s1_valid && (r_s1_hdr || !r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign eff_await     = r_await || s_axis_tuser;
    assign eff_first     = r_first || s_axis_tuser;
    assign in_last       = (CW'(r_col) + CW'(1)) >= len_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_first  <= 1'b1;
            r_col    <= '0;
            r_filter <= FILT_NONE;
            r_bad    <= 1'b0;
        end else if (in_acc) begin
            if (eff_await) begin
                r_bad    <= s_axis_tdata > DATA_W'(4);
                r_filter <= (s_axis_tdata > DATA_W'(4)) ? FILT_NONE
                                                       : t_filter'(s_axis_tdata[FILT_W-1:0]);
                r_await  <= 1'b0;
                r_first  <= eff_first;
                r_col    <= '0;
            end else if (in_last) begin
                r_await  <= 1'b1;
                r_first  <= 1'b0;
                r_col    <= '0;
            end else begin
                r_col    <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_hdr    <= eff_await;
            r_s1_x      <= s_axis_tdata;
            r_s1_first  <= r_first;
            r_s1_last   <= in_last;
            r_s1_bad    <= r_bad;
            r_s1_filter <= r_filter;
            r_s1_col    <= r_col;
        end
    end

    // reconstruction
    assign a      = r_left[win_idx];
    assign b      = r_s1_first ? '0 : mem_rdata;
    assign c      = r_s1_first ? '0 : r_upleft[win_idx];
    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        case (r_s1_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[DATA_W:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = '0;
        endcase
        recon = r_s1_x + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k]   <= '0;
                r_upleft[k] <= '0;
            end
        end else if (s1_adv) begin
            if (r_s1_hdr) begin
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    r_left[k]   <= '0;
                    r_upleft[k] <= '0;
                end
            end else begin
                for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                    r_left[k]   <= r_left[k-1];
                    r_upleft[k] <= r_upleft[k-1];
                end
                r_left[0]   <= recon;
                r_upleft[0] <= b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv && !r_s1_hdr) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !r_s1_hdr) begin
            r_m_data <= recon;
            r_m_last <= r_s1_last;
            r_m_bad  <= r_s1_bad;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_bad;

    // line store: read ahead at accept, write back as the byte leaves
    always_comb begin
        mem_ctl.we    = s1_adv && !r_s1_hdr;
        mem_ctl.re    = in_acc && !eff_await;
        mem_ctl.wdata = recon;
    end

    psu_line_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (r_s1_col),
        .i_raddr (r_col),
        .o_rdata (mem_rdata)
    );

endmodule
